>>> rtl/ssim_pkg.sv
// Shared constants, codes and control types of the sparse set index map.
`timescale 1ns / 1ps

package ssim_pkg;

	// Sizes of the two tables and the count.
	localparam int ENTITY_SLOTS = 4096;
	localparam int DENSE_DEPTH  = 1024;
	localparam int SLOT_W       = $clog2(ENTITY_SLOTS);
	localparam int POS_W        = $clog2(DENSE_DEPTH);
	localparam int CNT_W        = POS_W + 1;
	localparam int MAP_W        = POS_W + 1;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DENSE_DEPTH);
	localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(DENSE_DEPTH);

	// Register indexes on the configuration port.
	localparam logic REG_CAPACITY = 1'b0;

	// Request codes.
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_HAS    = 2'd2;
	localparam logic [1:0] REQ_INDEX  = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_PRESENT = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_DEAD    = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic accept;
		logic look;
		logic fix;
	} ssim_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic move;
	} ssim_sts_t;

endpackage

>>> rtl/ssim_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ssim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ssim_ctrl.sv
// Controller state machine: clearing pass, request lookup and second map write.
`timescale 1ns / 1ps

module ssim_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ssim_pkg::ssim_sts_t sts,
	output ssim_pkg::ssim_cmd_t cmd,
	output logic               busy
);

	import ssim_pkg::*;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;
	localparam logic [1:0] S_FIX   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				state_nxt = sts.move ? S_FIX : S_IDLE;
			end
			S_FIX: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.accept = (state_q == S_IDLE) && start;
	assign cmd.look   = (state_q == S_LOOK);
	assign cmd.fix    = (state_q == S_FIX);
	assign busy       = (state_q != S_IDLE);

endmodule

>>> rtl/ssim_dp.sv
// Datapath: slot map and dense table memories, entry count and result registers.
`timescale 1ns / 1ps

module ssim_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ssim_pkg::ssim_cmd_t          cmd,
	output ssim_pkg::ssim_sts_t          sts,
	input  logic [ssim_pkg::CNT_W-1:0]   capacity,
	input  logic [1:0]                   req_type,
	input  logic [ssim_pkg::SLOT_W-1:0]  entity_slot,
	input  logic                         entity_alive,
	output logic                         done,
	output logic [2:0]                   status,
	output logic [ssim_pkg::POS_W-1:0]   dense_pos,
	output logic                         present,
	output logic                         moved,
	output logic [ssim_pkg::POS_W-1:0]   moved_from,
	output logic [ssim_pkg::CNT_W-1:0]   entry_count
);

	import ssim_pkg::*;

	// Request latched at the accept edge.
	logic [1:0]        req_q;
	logic [SLOT_W-1:0] slot_q;
	logic              alive_q;

	logic [SLOT_W-1:0] clr_cnt_q;
	logic [CNT_W-1:0]  occ_q;

	// Memory ports.
	logic              map_we;
	logic [SLOT_W-1:0] map_waddr;
	logic [MAP_W-1:0]  map_wdata;
	logic [MAP_W-1:0]  map_rdata;
	logic              d2s_we;
	logic [POS_W-1:0]  d2s_waddr;
	logic [SLOT_W-1:0] d2s_wdata;
	logic [SLOT_W-1:0] d2s_rdata;

	// Decode of the looked-up entry.
	logic              hit;
	logic [POS_W-1:0]  hpos;
	logic [CNT_W-1:0]  last;
	logic [CNT_W-1:0]  cap_eff;
	logic              add_ok;
	logic              rem_ok;
	logic              move;
	logic [CNT_W-1:0]  occ_nxt;

	logic              done_q;
	logic [2:0]        status_q;
	logic [POS_W-1:0]  dense_pos_q;
	logic              present_q;
	logic              moved_q;
	logic [POS_W-1:0]  moved_from_q;
	logic [CNT_W-1:0]  entry_count_q;

	logic [2:0]        st_nxt;
	logic [POS_W-1:0]  pos_nxt;
	logic              pres_nxt;

	// The slot map is read straight from the request ports so that its entry is
	// ready in the lookup cycle; the dense table is read at the last position.
	ssim_ram #(.WIDTH(MAP_W), .DEPTH(ENTITY_SLOTS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (entity_slot),
		.rdata (map_rdata)
	);

	ssim_ram #(.WIDTH(SLOT_W), .DEPTH(DENSE_DEPTH)) u_d2s (
		.clk   (clk),
		.we    (d2s_we),
		.waddr (d2s_waddr),
		.wdata (d2s_wdata),
		.raddr (last[POS_W-1:0]),
		.rdata (d2s_rdata)
	);

	assign hit     = map_rdata[MAP_W-1];
	assign hpos    = map_rdata[POS_W-1:0];
	assign last    = occ_q - CNT_W'(1);
	assign cap_eff = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;

	assign add_ok = alive_q && (req_q == REQ_ADD) && !hit && (occ_q < cap_eff);
	assign rem_ok = alive_q && (req_q == REQ_REMOVE) && hit && (occ_q != '0)
		&& ({1'b0, hpos} < occ_q);
	assign move   = rem_ok && ({1'b0, hpos} != last);

	always_comb begin
		occ_nxt = occ_q;
		if (add_ok) begin
			occ_nxt = occ_q + CNT_W'(1);
		end else if (rem_ok) begin
			occ_nxt = last;
		end
	end

	// Slot map writes: clearing pass, add, relink of the moved entry, then
	// release of the removed slot (in the lookup cycle or the fix cycle).
	always_comb begin
		map_we    = 1'b0;
		map_waddr = slot_q;
		map_wdata = '0;
		if (cmd.clear) begin
			map_we    = 1'b1;
			map_waddr = clr_cnt_q;
		end else if (cmd.look) begin
			if (add_ok) begin
				map_we    = 1'b1;
				map_wdata = {1'b1, occ_q[POS_W-1:0]};
			end else if (move) begin
				map_we    = 1'b1;
				map_waddr = d2s_rdata;
				map_wdata = {1'b1, hpos};
			end else if (rem_ok) begin
				map_we = 1'b1;
			end
		end else if (cmd.fix) begin
			map_we = 1'b1;
		end
	end

	always_comb begin
		d2s_we    = 1'b0;
		d2s_waddr = occ_q[POS_W-1:0];
		d2s_wdata = slot_q;
		if (cmd.look && add_ok) begin
			d2s_we = 1'b1;
		end else if (cmd.look && move) begin
			d2s_we    = 1'b1;
			d2s_waddr = hpos;
			d2s_wdata = d2s_rdata;
		end
	end

	always_comb begin
		st_nxt   = ST_ABSENT;
		pos_nxt  = '0;
		pres_nxt = 1'b0;
		if (!alive_q) begin
			st_nxt = ST_DEAD;
		end else begin
			case (req_q)
				REQ_ADD: begin
					if (hit) begin
						st_nxt   = ST_PRESENT;
						pres_nxt = 1'b1;
					end else if (add_ok) begin
						st_nxt   = ST_OK;
						pos_nxt  = occ_q[POS_W-1:0];
						pres_nxt = 1'b1;
					end else begin
						st_nxt = ST_FULL;
					end
				end
				REQ_REMOVE: begin
					if (rem_ok) begin
						st_nxt  = ST_OK;
						pos_nxt = hpos;
					end else begin
						pres_nxt = hit;
					end
				end
				default: begin
					if (hit) begin
						st_nxt   = ST_OK;
						pos_nxt  = hpos;
						pres_nxt = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q   <= req_type;
			slot_q  <= entity_slot;
			alive_q <= entity_alive;
		end
		if (cmd.look) begin
			status_q      <= st_nxt;
			dense_pos_q   <= pos_nxt;
			present_q     <= pres_nxt;
			moved_q       <= move;
			moved_from_q  <= move ? last[POS_W-1:0] : '0;
			entry_count_q <= occ_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			occ_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.look;
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
			if (cmd.look) begin
				occ_q <= occ_nxt;
			end
		end
	end

	assign sts.clear_last = (clr_cnt_q == SLOT_W'(ENTITY_SLOTS - 1));
	assign sts.move       = move;

	assign done        = done_q;
	assign status      = status_q;
	assign dense_pos   = dense_pos_q;
	assign present     = present_q;
	assign moved       = moved_q;
	assign moved_from  = moved_from_q;
	assign entry_count = entry_count_q;

endmodule

>>> rtl/sparse_set_index_map_core.sv
// Top level of the sparse set index map with swap-remove and its register port.
`timescale 1ns / 1ps

// The block maps entity slots (0 to 4095) to packed dense positions and keeps
// the reverse table and the entry count, for add, remove, has and index lookup
// requests. A request beat is taken at a clock edge where start is high and
// busy is low. Its one result beat appears on the result ports, marked by done,
// for exactly one cycle and cannot be held off by the receiver. It shows in
// the cycle after the lookup; the next request is taken once the block is idle
// again. A remove that moves the last entry into the freed position also passes
// through a fix state, as the slot map has one write port and that request
// writes it twice. After reset the block runs a clearing pass over the slot map,
// one entry per cycle; busy stays high throughout and no request is taken,
// though the capacity register can be written. Capacity is held at offset 0 of
// the register port, resets to 1024, and values above 1024 act as 1024. The user
// must change capacity only while no request is in flight; this is not enforced.
module sparse_set_index_map_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request channel.
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       req_type,
	input  logic [ssim_pkg::SLOT_W-1:0]      entity_slot,
	input  logic                             entity_alive,
	// Result channel.
	output logic                             done,
	output logic [2:0]                       status,
	output logic [ssim_pkg::POS_W-1:0]       dense_pos,
	output logic                             present,
	output logic                             moved,
	output logic [ssim_pkg::POS_W-1:0]       moved_from,
	output logic [ssim_pkg::CNT_W-1:0]       entry_count,
	// Register port.
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ssim_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ssim_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ssim_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);

	import ssim_pkg::*;

	ssim_cmd_t        cmd;
	ssim_sts_t        sts;
	logic [CNT_W-1:0] capacity_q;
	logic             reg_sel;

	// Register decode: the word index sits above the byte offset bits.
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_CAPACITY);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			capacity_q <= pwdata[CNT_W-1:0];
		end
	end

	ssim_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ssim_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.capacity     (capacity_q),
		.req_type     (req_type),
		.entity_slot  (entity_slot),
		.entity_alive (entity_alive),
		.done         (done),
		.status       (status),
		.dense_pos    (dense_pos),
		.present      (present),
		.moved        (moved),
		.moved_from   (moved_from),
		.entry_count  (entry_count)
	);

`ifndef SYNTHESIS
	// An accepted request keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a request beat was taken");

	// A result beat only follows a cycle in which the block was busy.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a request in flight");

	// The count never exceeds the dense table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count <= CAP_LIMIT))
		else $error("entry count beyond dense depth");

	// A request for a dead entity reports nothing else.
	a_dead_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_DEAD) |-> (!present && !moved && dense_pos == '0))
		else $error("not-alive result carries data");

	// A move is reported only by a successful remove.
	a_move_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && moved) |-> (status == ST_OK && !present))
		else $error("move reported outside a successful remove");
`endif

endmodule

>>> verif/sparse_set_index_map_core_test.sv
// Self-checking testbench for the sparse set index map core with swap-remove.
`timescale 1ns / 1ps

// The test drives request beats on the command port and predicts each result
// with its own copy of the slot map, the reverse dense table, the entry count
// and the capacity register. Every result beat that done marks is compared,
// field by field, with the oldest waiting prediction.
//
// A short directed section comes first. It covers requests for dead entities,
// queries on an empty set, adds and lookups at the slot extremes, and a
// duplicate add. It also covers removes that swap the last entry into the
// hole, a remove of the last entry, and removes of absent entities. Capacity
// is tried at zero and one, above the table depth, and below the current
// count. Several random phases follow, each with its own capacity setting.
// Most random beats name live entities or a small pool of slots so that
// removes and queries hit. The rest are random slots or dead entities.
module sparse_set_index_map_core_test;
	import ssim_pkg::*;

	// Address of the capacity register on the register port.
	localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(4 * REG_CAPACITY);
	// Size of the pool of slots that random beats reuse.
	localparam int POOL_SIZE = 48;
	// Random beats in each random phase.
	localparam int PHASE_BEATS = 90;

	typedef struct packed {
		logic [2:0]       status;
		logic [POS_W-1:0] dense_pos;
		logic             present;
		logic             moved;
		logic [POS_W-1:0] moved_from;
		logic [CNT_W-1:0] entry_count;
	} map_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            req_type = REQ_ADD;
	logic [SLOT_W-1:0]     entity_slot = '0;
	logic                  entity_alive = 1'b0;
	logic                  done;
	logic [2:0]            status;
	logic [POS_W-1:0]      dense_pos;
	logic                  present;
	logic                  moved;
	logic [POS_W-1:0]      moved_from;
	logic [CNT_W-1:0]      entry_count;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Predicted state of the block.
	bit                    slot_live [ENTITY_SLOTS];
	int                    slot_dense [ENTITY_SLOTS];
	logic [SLOT_W-1:0]     dense_slot [DENSE_DEPTH];
	int                    live_count = 0;
	logic [CNT_W-1:0]      cap_setting = CAP_RESET;

	// Predicted results in the order the block must deliver them.
	map_result_t           pending_results [$];
	logic [SLOT_W-1:0]     slot_pool [POOL_SIZE];

	// When set, the sender holds start high with no gaps at all.
	bit                    no_gaps = 1'b0;
	int                    errors = 0;
	int                    beats_sent = 0;
	int                    adds_sent = 0;
	int                    removes_sent = 0;
	int                    queries_sent = 0;
	int                    cap_writes = 0;
	int                    swaps_seen = 0;
	int                    full_seen = 0;
	int                    dup_seen = 0;
	int                    dead_seen = 0;

	sparse_set_index_map_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.entity_slot(entity_slot),
		.entity_alive(entity_alive),
		.done(done),
		.status(status),
		.dense_pos(dense_pos),
		.present(present),
		.moved(moved),
		.moved_from(moved_from),
		.entry_count(entry_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one request to the predicted state and returns its result.
	function automatic map_result_t apply_map_request(logic [1:0] kind,
			logic [SLOT_W-1:0] slot, logic alive);
		map_result_t r;
		int limit;
		int pos;
		int last;
		logic [SLOT_W-1:0] other;
		r = '0;
		r.status = ST_OK;
		limit = (int'(cap_setting) > DENSE_DEPTH) ? DENSE_DEPTH : int'(cap_setting);
		if (!alive) begin
			// A dead entity never touches the tables.
			r.status = ST_DEAD;
		end else begin
			case (kind)
			REQ_ADD: begin
				// Already present wins over full.
				if (slot_live[slot]) begin
					r.status = ST_PRESENT;
					r.present = 1'b1;
				end else if (live_count >= limit) begin
					r.status = ST_FULL;
				end else begin
					slot_live[slot] = 1'b1;
					slot_dense[slot] = live_count;
					dense_slot[live_count] = slot;
					r.dense_pos = POS_W'(live_count);
					r.present = 1'b1;
					live_count++;
				end
			end
			REQ_REMOVE: begin
				if (!slot_live[slot] || live_count == 0 || slot_dense[slot] >= live_count) begin
					r.status = ST_ABSENT;
					r.present = slot_live[slot];
				end else begin
					pos = slot_dense[slot];
					last = live_count - 1;
					// The last entry fills the hole unless it is the one removed.
					if (pos != last) begin
						other = dense_slot[last];
						dense_slot[pos] = other;
						slot_dense[other] = pos;
						r.moved = 1'b1;
						r.moved_from = POS_W'(last);
					end
					slot_live[slot] = 1'b0;
					slot_dense[slot] = 0;
					live_count = last;
					r.dense_pos = POS_W'(pos);
				end
			end
			default: begin
				// Has and index lookup read the map only.
				if (slot_live[slot]) begin
					r.dense_pos = POS_W'(slot_dense[slot]);
					r.present = 1'b1;
				end else begin
					r.status = ST_ABSENT;
				end
			end
			endcase
		end
		r.entry_count = CNT_W'(live_count);
		return r;
	endfunction

	// Sends one request beat and records its prediction at the accepting edge.
	// Start is left high on return, so the caller must either send the next
	// beat or lower start in the same time step.
	task automatic send_request(logic [1:0] kind, logic [SLOT_W-1:0] slot, logic alive);
		if (!no_gaps && $urandom_range(99) < 24) begin
			start <= 1'b0;
			repeat ($urandom_range(2, 6)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		entity_slot <= slot;
		entity_alive <= alive;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(apply_map_request(kind, slot, alive));
		beats_sent++;
		case (kind)
		REQ_ADD: adds_sent++;
		REQ_REMOVE: removes_sent++;
		default: queries_sent++;
		endcase
	endtask

	// Lowers start and waits until every predicted result has come back,
	// then lets the trailing table writes of the last request finish.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the capacity register with a setup and an access cycle.
	task automatic set_capacity(logic [CNT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_setting = value;
		cap_writes++;
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Every result beat is taken at the edge that ends its done cycle.
	always @(posedge clk) begin
		map_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result beat with no request waiting, status %0d",
					$time, status);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 16'(want.status), 16'(status));
				check_field("dense_pos", 16'(want.dense_pos), 16'(dense_pos));
				check_field("present", 16'(want.present), 16'(present));
				check_field("moved", 16'(want.moved), 16'(moved));
				check_field("moved_from", 16'(want.moved_from), 16'(moved_from));
				check_field("entry_count", 16'(want.entry_count), 16'(entry_count));
				if (moved === 1'b1) swaps_seen++;
				if (status === ST_FULL) full_seen++;
				if (status === ST_PRESENT) dup_seen++;
				if (status === ST_DEAD) dead_seen++;
			end
		end
	end

	// Dead entities, for every request type, change nothing.
	task automatic test_not_alive();
		send_request(REQ_ADD, '1, 1'b0);
		send_request(REQ_REMOVE, '0, 1'b0);
		send_request(REQ_HAS, 12'hAAA, 1'b0);
		send_request(REQ_INDEX, 12'h555, 1'b0);
	endtask

	// Queries and a remove on the empty set all report not present.
	task automatic test_empty_set();
		send_request(REQ_HAS, '0, 1'b1);
		send_request(REQ_INDEX, '1, 1'b1);
		send_request(REQ_REMOVE, 12'd77, 1'b1);
	endtask

	// Adds at the slot extremes, a duplicate add, and lookups of both kinds.
	task automatic test_add_lookup();
		send_request(REQ_ADD, '0, 1'b1);
		send_request(REQ_ADD, '1, 1'b1);
		send_request(REQ_ADD, 12'hAAA, 1'b1);
		send_request(REQ_ADD, 12'h555, 1'b1);
		send_request(REQ_ADD, '0, 1'b1);
		send_request(REQ_HAS, '1, 1'b1);
		send_request(REQ_INDEX, 12'h555, 1'b1);
	endtask

	// Removes that swap the last entry in, a remove of the last entry itself,
	// and a second remove of a slot that is already gone.
	task automatic test_swap_remove();
		send_request(REQ_REMOVE, '0, 1'b1);
		send_request(REQ_INDEX, 12'h555, 1'b1);
		send_request(REQ_REMOVE, '1, 1'b1);
		send_request(REQ_REMOVE, '1, 1'b1);
		send_request(REQ_ADD, 12'd100, 1'b1);
		send_request(REQ_REMOVE, 12'd100, 1'b1);
	endtask

	// Capacity at zero, at one, above the table depth and below the count.
	task automatic test_capacity_edges();
		wait_idle();
		set_capacity('0);
		send_request(REQ_ADD, 12'd5, 1'b1);
		wait_idle();
		set_capacity(CNT_W'(1));
		send_request(REQ_ADD, 12'h555, 1'b1);
		send_request(REQ_ADD, 12'd9, 1'b1);
		wait_idle();
		set_capacity('1);
		send_request(REQ_ADD, 12'd10, 1'b1);
		send_request(REQ_ADD, 12'd11, 1'b1);
		wait_idle();
		set_capacity(CNT_W'(1));
		send_request(REQ_ADD, 12'd12, 1'b1);
		send_request(REQ_REMOVE, 12'd10, 1'b1);
	endtask

	// One phase of random traffic under the given capacity.
	task automatic test_random_phase(logic [CNT_W-1:0] cap, bit steady);
		logic [1:0] kind;
		logic [SLOT_W-1:0] slot;
		int pick;
		wait_idle();
		set_capacity(cap);
		no_gaps = steady;
		for (int i = 0; i < PHASE_BEATS; i++) begin
			pick = $urandom_range(99);
			kind = (pick < 35) ? REQ_ADD : (pick < 65) ? REQ_REMOVE :
				(pick < 80) ? REQ_HAS : REQ_INDEX;
			// Mostly name live entities or pooled slots, so removes and
			// queries find something; the rest is spread over all slots.
			pick = $urandom_range(99);
			if (pick < 45 && live_count > 0)
				slot = dense_slot[$urandom_range(live_count - 1)];
			else if (pick < 85)
				slot = slot_pool[$urandom_range(POOL_SIZE - 1)];
			else
				slot = SLOT_W'($urandom_range(ENTITY_SLOTS - 1));
			send_request(kind, slot, $urandom_range(99) < 90);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		foreach (slot_pool[i]) slot_pool[i] = SLOT_W'($urandom_range(ENTITY_SLOTS - 1));
		slot_pool[0] = '0;
		slot_pool[1] = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its slot map after reset; the first beat simply
		// waits on busy until that pass is over.
		test_not_alive();
		test_empty_set();
		test_add_lookup();
		test_swap_remove();
		test_capacity_edges();

		test_random_phase(CNT_W'(16), 1'b0);
		test_random_phase(CAP_LIMIT, 1'b1);
		test_random_phase(CNT_W'(4), 1'b0);
		test_random_phase('1, 1'b0);
		test_random_phase(CNT_W'(40), 1'b0);

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d request beats: %0d adds, %0d removes, %0d queries, %0d capacity writes.",
			beats_sent, adds_sent, removes_sent, queries_sent, cap_writes);
		$display("Seen %0d swap moves, %0d full, %0d already present, %0d not alive results.",
			swaps_seen, full_seen, dup_seen, dead_seen);
		if (errors == 0) begin
			$display("sparse_set_index_map_core_test passed");
		end else begin
			$display("sparse_set_index_map_core_test failed");
		end
		$finish;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#3_000_000;
		$display("sparse_set_index_map_core_test failed");
		$finish;
	end

endmodule
